### sv/decimating_complex_fir_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimating complex FIR unit
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DECIMATING_COMPLEX_FIR_UNIT_MACROS_SVH
`define DECIMATING_COMPLEX_FIR_UNIT_MACROS_SVH

// same-cycle implication
`define DCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants of the decimating complex FIR unit.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int SMP_W     = 16;
    localparam int ADDR_MAX_W = 8;   // holds any tap index up to 256 taps
    localparam int CNT_MAX_W  = 9;   // holds a tap count up to 256
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_MODE  = 2'd2;

    // command from front to back
    typedef struct packed {
        logic                  coef_wr;
        logic [SMP_W-1:0]      re;
        logic [SMP_W-1:0]      im;
        logic [ADDR_MAX_W-1:0] addr;
        logic                  produce;
        logic                  clear;
        logic [CNT_MAX_W-1:0]  taps;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_EMIT
    } back_state_t;

endpackage

### sv/dcf_ifs.sv
// ----------------------------------------------------------------------------
// dcf channel interfaces
// Valid/ready channels for input items and filter results.
// ----------------------------------------------------------------------------
interface dcf_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               block_end;
    logic        [4:0]  coef_index;
    logic signed [15:0] coef_re;
    logic signed [15:0] coef_im;

    modport source (output valid, action, sample_re, sample_im, block_end,
                    coef_index, coef_re, coef_im, input ready);
    modport sink   (input valid, action, sample_re, sample_im, block_end,
                    coef_index, coef_re, coef_im, output ready);
endinterface

interface dcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;

    modport source (output valid, out_re, out_im, input ready);
    modport sink   (input valid, out_re, out_im, output ready);
endinterface

### sv/decimating_complex_fir_unit.sv
// ----------------------------------------------------------------------------
// decimating_complex_fir_unit
// Decimating complex FIR filter, Q1.15 in and out, with loadable taps.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | carries
//  din     | in  | valid/ready        | sample or coefficient write item
//  dout    | out | valid/ready        | out_re, out_im
//  cfg     | in  | cfg_wr_en (no wait)| decimation, tap_count, save_mode
//
//  The back end takes a coefficient write or a sample that yields no output
//  straight from idle. For a sample that yields an output, one complex MAC
//  walks the taps, one history and one coefficient read per cycle, then
//  rounds. Reset clears the delay line valid bits, the phase and write
//  pointer, and config to 1/32/1; no clearing pass. A two-entry queue lets
//  din keep transferring while the back end works; the output register
//  frees the MAC while a result waits on dout.
// ----------------------------------------------------------------------------
`include "decimating_complex_fir_unit_macros.svh"

module decimating_complex_fir_unit #(
    parameter int TAPS           = 32,
    parameter int MAX_DECIMATION = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dcf_in_if.sink                           din,
    dcf_out_if.source                        dout,
    input  logic                             cfg_wr_en,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcf_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import dcf_pkg::*;

    logic [4:0] decimation_reg;
    logic [5:0] tap_count_reg;
    logic       save_mode_reg;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimation_reg <= 5'd1;
            tap_count_reg  <= 6'd32;
            save_mode_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DECIMATION: decimation_reg <= cfg_data[4:0];
                REG_TAP_COUNT:  tap_count_reg  <= cfg_data[5:0];
                REG_SAVE_MODE:  save_mode_reg  <= cfg_data[0];
                default:        save_mode_reg  <= save_mode_reg;
            endcase
        end
    end

    // front: classify items, phase and write pointer
    dcf_front #(
        .TAPS           (TAPS),
        .MAX_DECIMATION (MAX_DECIMATION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .decimation (decimation_reg),
        .tap_count  (tap_count_reg),
        .save_mode  (save_mode_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (push_cmd)
    );

    dcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: storage, MAC, rounding, result register
    dcf_back #(
        .TAPS (TAPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_cmd),
        .q_empty (q_empty),
        .pop     (q_pop),
        .dout    (dout)
    );

    `DCF_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")
    `DCF_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "pop from empty queue")
    `DCF_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed command lost")
endmodule

### sv/dcf_queue.sv
// ----------------------------------------------------------------------------
// dcf_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module dcf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dcf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output dcf_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import dcf_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end
endmodule

### sv/dcf_front.sv
// ----------------------------------------------------------------------------
// dcf_front
// Takes input items, tracks phase and write pointer, issues commands.
// ----------------------------------------------------------------------------
module dcf_front #(
    parameter int TAPS           = 32,
    parameter int MAX_DECIMATION = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dcf_in_if.sink        din,
    input  logic [4:0]    decimation,
    input  logic [5:0]    tap_count,
    input  logic          save_mode,
    input  logic          q_full,
    output logic          push,
    output dcf_pkg::cmd_t push_cmd
);
    import dcf_pkg::*;

    localparam int WP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PH_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;

    logic [WP_W-1:0]      wp_reg, wp_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic                 accept;
    logic [CNT_MAX_W-1:0] d_eff, m_eff;
    logic                 produce, clear, coef_ok;

    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;

    always_comb
    begin
        d_eff = {4'd0, decimation};
        if (decimation == 5'd0)
            d_eff = CNT_MAX_W'(1);
        else if (d_eff > CNT_MAX_W'(MAX_DECIMATION))
            d_eff = CNT_MAX_W'(MAX_DECIMATION);
        m_eff = {3'd0, tap_count};
        if (tap_count == 6'd0)
            m_eff = CNT_MAX_W'(1);
        else if (m_eff > CNT_MAX_W'(TAPS))
            m_eff = CNT_MAX_W'(TAPS);
    end

    assign produce = (phase_reg == '0);
    assign clear   = din.block_end && !save_mode;
    assign coef_ok = (int'(din.coef_index) < TAPS);

    always_comb
    begin
        push_cmd         = '0;
        push_cmd.coef_wr = din.action;
        push_cmd.taps    = m_eff;
        if (din.action)
        begin
            push_cmd.re   = din.coef_re;
            push_cmd.im   = din.coef_im;
            push_cmd.addr = ADDR_MAX_W'(din.coef_index);
        end
        else
        begin
            push_cmd.re      = din.sample_re;
            push_cmd.im      = din.sample_im;
            push_cmd.addr    = ADDR_MAX_W'(wp_reg);
            push_cmd.produce = produce;
            push_cmd.clear   = clear;
        end
        // out-of-range coefficient writes are dropped here
        push = accept && (!din.action || coef_ok);
    end

    always_comb
    begin
        wp_next    = wp_reg;
        phase_next = phase_reg;
        if (accept && !din.action)
        begin
            wp_next    = (int'(wp_reg) == TAPS - 1) ? '0 : wp_reg + WP_W'(1);
            phase_next = produce ? PH_W'(d_eff - CNT_MAX_W'(1)) : phase_reg - PH_W'(1);
            if (clear)
            begin
                wp_next    = '0;
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            phase_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            phase_reg <= phase_next;
        end
    end
endmodule

### sv/dcf_back.sv
// ----------------------------------------------------------------------------
// dcf_back
// Delay line, coefficient store, shared complex MAC and output register.
// ----------------------------------------------------------------------------
module dcf_back #(
    parameter int TAPS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dcf_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    dcf_out_if.source     dout
);
    import dcf_pkg::*;

    localparam int WP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = 34 + $clog2(TAPS + 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(16384);

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;

    logic [2*SMP_W-1:0] hist_mem [TAPS];
    logic [2*SMP_W-1:0] coef_mem [TAPS];
    logic [TAPS-1:0]    hvalid_reg;

    logic [CNT_MAX_W-1:0] k_reg;
    logic [WP_W-1:0]      rd_idx_reg;
    logic                 p1_reg, p2_reg;
    logic [2*SMP_W-1:0]   hist_q_reg, coef_q_reg;
    logic                 hv_q_reg;
    logic signed [31:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [15:0]   out_re_reg, out_im_reg;
    logic                 out_valid_reg;

    logic hist_we, coef_we, start, rd_en, clr_all, load_out, last_issue, out_free;
    logic signed [15:0]   hr, hi, xr, xi;
    logic signed [ACC_W-1:0] v_re, v_im, q_re, q_im;
    logic signed [15:0]   r_re, r_im;

    assign last_issue = (k_reg == cmd_reg.taps - CNT_MAX_W'(1));
    assign out_free   = !out_valid_reg || dout.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!q_empty && !head.coef_wr && head.produce)
                    state_next = BK_MAC;
            BK_MAC:
                if (last_issue)
                    state_next = BK_DRAIN;
            BK_DRAIN:
                if (!p1_reg && !p2_reg)
                    state_next = BK_EMIT;
            BK_EMIT:
                if (out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        hist_we  = 1'b0;
        coef_we  = 1'b0;
        start    = 1'b0;
        rd_en    = 1'b0;
        clr_all  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
                if (!q_empty)
                begin
                    pop     = 1'b1;
                    coef_we = head.coef_wr;
                    hist_we = !head.coef_wr;
                    start   = !head.coef_wr && head.produce;
                    clr_all = !head.coef_wr && !head.produce && head.clear;
                end
            BK_MAC:
                rd_en = 1'b1;
            BK_DRAIN:
                rd_en = 1'b0;
            BK_EMIT:
                if (out_free)
                begin
                    load_out = 1'b1;
                    clr_all  = cmd_reg.clear;
                end
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            hvalid_reg    <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_all)
                hvalid_reg <= '0;
            else if (hist_we)
                hvalid_reg[head.addr[WP_W-1:0]] <= 1'b1;
            p1_reg <= rd_en;
            p2_reg <= p1_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[head.addr[WP_W-1:0]] <= {head.re, head.im};
        if (coef_we)
            coef_mem[head.addr[WP_W-1:0]] <= {head.re, head.im};
        if (rd_en)
        begin
            hist_q_reg <= hist_mem[rd_idx_reg];
            coef_q_reg <= coef_mem[k_reg[WP_W-1:0]];
            hv_q_reg   <= hvalid_reg[rd_idx_reg];
        end
    end

    // unwritten history reads as zero
    assign hr = signed'(coef_q_reg[31:16]);
    assign hi = signed'(coef_q_reg[15:0]);
    assign xr = hv_q_reg ? signed'(hist_q_reg[31:16]) : 16'sd0;
    assign xi = hv_q_reg ? signed'(hist_q_reg[15:0])  : 16'sd0;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg    <= head;
            k_reg      <= '0;
            rd_idx_reg <= head.addr[WP_W-1:0];
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                k_reg      <= k_reg + CNT_MAX_W'(1);
                rd_idx_reg <= (rd_idx_reg == '0) ? WP_W'(TAPS - 1) : rd_idx_reg - WP_W'(1);
            end
            if (p2_reg)
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
                acc_im_reg <= acc_im_reg + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
            end
        end
        if (p1_reg)
        begin
            p_rr_reg <= hr * xr;
            p_ii_reg <= hi * xi;
            p_ri_reg <= hr * xi;
            p_ir_reg <= hi * xr;
        end
        if (load_out)
        begin
            out_re_reg <= r_re;
            out_im_reg <= r_im;
        end
    end

    // round to nearest, ties up, then saturate
    always_comb
    begin
        v_re = acc_re_reg + HALF;
        v_im = acc_im_reg + HALF;
        q_re = v_re >>> 15;
        q_im = v_im >>> 15;
        if (q_re > SAT_HI)
            r_re = 16'sh7FFF;
        else if (q_re < SAT_LO)
            r_re = -16'sh8000;
        else
            r_re = q_re[15:0];
        if (q_im > SAT_HI)
            r_im = 16'sh7FFF;
        else if (q_im < SAT_LO)
            r_im = -16'sh8000;
        else
            r_im = q_im[15:0];
    end

    assign dout.valid  = out_valid_reg;
    assign dout.out_re = out_re_reg;
    assign dout.out_im = out_im_reg;
endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimating complex FIR unit. Loads the taps,
// runs directed edge cases and then randomized sample streams over a range of
// register settings. An in-bench model predicts each filter output. The
// result channel is compared against it, field by field and in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    localparam int          NTAPS   = 32;
    localparam int          MAX_DEC = 16;
    localparam logic        ACT_SAMPLE = 1'b0;
    localparam logic        ACT_COEF   = 1'b1;
    localparam int          SETTLE_CYCLES = 64;   // back end + input queue drain
    localparam int          HOLD_CYCLES   = 400;  // long output back-pressure
    localparam int          STALL_LIMIT   = 4000; // cycles with no transfer

    typedef struct {
        logic               action;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               block_end;
        logic        [4:0]  coef_index;
        logic signed [15:0] coef_re;
        logic signed [15:0] coef_im;
    } fir_item_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } fir_sample_t;

    // ------------------------------------------------------------------------
    // Filter model plus queue of predicted outputs
    // ------------------------------------------------------------------------
    class fir_scoreboard;
        fir_sample_t        predicted[$];
        logic signed [15:0] hist_re[NTAPS];
        logic signed [15:0] hist_im[NTAPS];
        logic signed [15:0] tap_re[NTAPS];
        logic signed [15:0] tap_im[NTAPS];
        int                 phase;
        int                 wr_ptr;
        logic [4:0]         decimation;
        logic [5:0]         tap_count;
        logic               save_mode;
        int                 mismatches;

        function new();
            clear_line();
            decimation = 5'd1;
            tap_count  = 6'd32;
            save_mode  = 1'b1;
            mismatches = 0;
        endfunction

        function void clear_line();
            foreach (hist_re[i])
            begin
                hist_re[i] = '0;
                hist_im[i] = '0;
            end
            phase  = 0;
            wr_ptr = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_DECIMATION: decimation = val[4:0];
                REG_TAP_COUNT:  tap_count  = val[5:0];
                REG_SAVE_MODE:  save_mode  = val[0];
                default: ;
            endcase
        endfunction

        // round half up from Q2.30 sum to Q1.15, then saturate
        function logic signed [15:0] to_q15(longint acc);
            longint q;
            q = (acc + 16384) >>> 15;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[15:0];
        endfunction

        // one accepted input transfer
        function void take_item(fir_item_t it);
            int          dec;
            int          taps;
            int          pos;
            longint      acc_re;
            longint      acc_im;
            fir_sample_t y;
            if (it.action == ACT_COEF)
            begin
                tap_re[it.coef_index] = it.coef_re;
                tap_im[it.coef_index] = it.coef_im;
                return;
            end
            dec  = (decimation < 1) ? 1 : (decimation > MAX_DEC) ? MAX_DEC : decimation;
            taps = (tap_count < 1) ? 1 : (tap_count > NTAPS) ? NTAPS : tap_count;
            hist_re[wr_ptr] = it.sample_re;
            hist_im[wr_ptr] = it.sample_im;
            if (phase == 0)
            begin
                acc_re = 0;
                acc_im = 0;
                for (int k = 0; k < taps; k++)
                begin
                    pos = (wr_ptr - k + NTAPS) % NTAPS;
                    acc_re += longint'(tap_re[k]) * hist_re[pos]
                            - longint'(tap_im[k]) * hist_im[pos];
                    acc_im += longint'(tap_re[k]) * hist_im[pos]
                            + longint'(tap_im[k]) * hist_re[pos];
                end
                y.re = to_q15(acc_re);
                y.im = to_q15(acc_im);
                predicted.push_back(y);
                phase = dec - 1;
            end
            else
                phase--;
            wr_ptr = (wr_ptr + 1) % NTAPS;
            if (it.block_end && !save_mode)
                clear_line();
        endfunction

        // one accepted output transfer
        function void check_result(logic signed [15:0] re, logic signed [15:0] im);
            fir_sample_t y;
            if (predicted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output re=%0d im=%0d", re, im);
                return;
            end
            y = predicted.pop_front();
            if (re !== y.re || im !== y.im)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                             y.re, y.im, re, im);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    dcf_in_if  din_ch();
    dcf_out_if dout_ch();

    decimating_complex_fir_unit #(
        .TAPS           (NTAPS),
        .MAX_DECIMATION (MAX_DEC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_ch),
        .dout      (dout_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fir_scoreboard sb = new();

    bit fast_send;   // sender offers back to back
    bit fast_recv;   // receiver never stalls
    bit hold_req;    // receiver: one long hold-off
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which nothing moves
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side: drive at the falling edge, see the transfer at the rising
    // ------------------------------------------------------------------------
    task automatic send_item(fir_item_t it);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_ch.action     <= it.action;
        din_ch.sample_re  <= it.sample_re;
        din_ch.sample_im  <= it.sample_im;
        din_ch.block_end  <= it.block_end;
        din_ch.coef_index <= it.coef_index;
        din_ch.coef_re    <= it.coef_re;
        din_ch.coef_im    <= it.coef_im;
        din_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!din_ch.ready);
        sb.take_item(it);
        @(negedge clk);
    endtask

    function automatic fir_item_t rand_item(bit is_coef, int be_odds);
        fir_item_t it;
        it.action     = is_coef ? ACT_COEF : ACT_SAMPLE;
        it.sample_re  = 16'($urandom);
        it.sample_im  = 16'($urandom);
        it.block_end  = ($urandom_range(0, be_odds) == 0);
        it.coef_index = 5'($urandom);
        it.coef_re    = 16'($urandom);
        it.coef_im    = 16'($urandom);
        return it;
    endfunction

    function automatic fir_item_t sample_of(int re, int im, bit be);
        fir_item_t it;
        it = rand_item(1'b0, 1);
        it.sample_re = 16'(re);
        it.sample_im = 16'(im);
        it.block_end = be;
        return it;
    endfunction

    // wait until every predicted output has arrived and the back end is quiet
    task automatic drain();
        din_ch.valid <= 1'b0;
        while (sb.predicted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(int dec, int taps, int save);
        drain();
        write_reg(REG_DECIMATION, CFG_DAT_W'(dec));
        write_reg(REG_TAP_COUNT, CFG_DAT_W'(taps));
        write_reg(REG_SAVE_MODE, CFG_DAT_W'(save));
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        dout_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                dout_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = fast_recv ? 0 : $urandom_range(0, 16);
                if (stall > 0)
                begin
                    dout_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            dout_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dout_ch.valid);
            sb.check_result(dout_ch.out_re, dout_ch.out_im);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        fir_item_t it;
        int        sent;
        int        n;
        int        be_odds;

        din_ch.valid      = 1'b0;
        din_ch.action     = ACT_SAMPLE;
        din_ch.sample_re  = '0;
        din_ch.sample_im  = '0;
        din_ch.block_end  = 1'b0;
        din_ch.coef_index = '0;
        din_ch.coef_re    = '0;
        din_ch.coef_im    = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        fast_send         = 1'b0;
        fast_recv         = 1'b0;
        hold_req          = 1'b0;
        rst_n             = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // load every tap first so no unwritten tap is ever read;
        // taps 0 and 1 hold the full-scale corners
        for (int k = 0; k < NTAPS; k++)
        begin
            it = rand_item(1'b1, 1);
            it.coef_index = 5'(k);
            if (k == 0)
            begin
                it.coef_re = 16'(-32768);
                it.coef_im = 16'(-32768);
            end
            else if (k == 1)
            begin
                it.coef_re = 16'(32767);
                it.coef_im = 16'(32767);
            end
            send_item(it);
        end

        // reset settings: full length, no decimation, save mode
        send_item(sample_of(-32768, -32768, 1'b0));
        send_item(sample_of(32767, 32767, 1'b1));   // block end ignored in save mode
        send_item(sample_of(-32768, 32767, 1'b0));
        send_item(sample_of(0, 0, 1'b0));

        // zero in both count registers acts as one; (-1-1j)^2 saturates
        set_all(0, 0, 1);
        send_item(sample_of(-32768, -32768, 1'b0));
        send_item(sample_of(32767, -32768, 1'b0));

        // counts above the maximum clamp
        set_all(31, 63, 1);
        for (int i = 0; i < 18; i++)
            send_item(rand_item(1'b0, 1000));

        // clear at block end, both ending mid-phase; tap rewrite mid-stream
        set_all(3, 5, 0);
        send_item(sample_of(1000, -1000, 1'b0));
        send_item(sample_of(32767, 32767, 1'b1));
        send_item(sample_of(-5, 7, 1'b0));
        send_item(rand_item(1'b1, 1));
        send_item(sample_of(-32768, 12, 1'b1));
        send_item(sample_of(99, -99, 1'b0));

        // decimation change mid-stream: phase keeps counting down
        drain();
        write_reg(REG_DECIMATION, CFG_DAT_W'(16));
        send_item(sample_of(123, 456, 1'b0));
        send_item(sample_of(-123, -456, 1'b0));
        drain();
        write_reg(REG_DECIMATION, CFG_DAT_W'(2));
        for (int i = 0; i < 20; i++)
            send_item(rand_item(1'b0, 1000));

        // long output hold-off while inputs keep coming: block fills up
        set_all(1, 2, 1);
        fast_send = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < 24; i++)
            send_item(rand_item(1'b0, 1000));
        fast_send = 1'b0;

        // randomized phases; sizes mostly small, extremes now and then
        sent = 0;
        while (sent < 450)
        begin
            case ($urandom_range(0, 5))
                0:       set_all(1, 32, $urandom_range(0, 1));
                1:       set_all($urandom_range(0, 31), $urandom_range(0, 63),
                                 $urandom_range(0, 1));
                2:       set_all(16, $urandom_range(1, 4), 0);
                default: set_all($urandom_range(1, 4), $urandom_range(1, 8),
                                 $urandom_range(0, 1));
            endcase
            fast_send = ($urandom_range(0, 3) == 0);
            fast_recv = ($urandom_range(0, 3) == 0);
            be_odds   = $urandom_range(2, 20);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++)
                send_item(rand_item($urandom_range(0, 9) == 0, be_odds));
            sent += n;
        end
        fast_send = 1'b0;
        fast_recv = 1'b0;

        // end of run: all outputs in, then a quiet tail for strays
        drain();
        if (sb.mismatches == 0 && sb.predicted.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
